// File: hw/rtl/salc_pkg.sv
`default_nettype none

package salc_pkg;

  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned KEY_W   = 62;
  localparam int unsigned STAMP_W = 64;

  // Configuration port.
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 5;
  localparam int unsigned OFF_W     = 4;
  localparam int unsigned WL_W      = 2;
  localparam int unsigned VIC_W     = 5;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS_LOG2    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VICTIMS      = 2'd2;

  localparam logic [OFF_W-1:0] OFF_RESET = 4'd4;
  localparam logic [OFF_W-1:0] OFF_MIN   = 4'd2;
  localparam logic [OFF_W-1:0] OFF_MAX   = 4'd8;

  // Largest victim count that the register field can express.
  localparam int unsigned VIC_FIELD_MAX = (1 << VIC_W) - 1;

  typedef enum logic [1:0] {
    OUT_MAIN_HIT   = 2'd0,
    OUT_VICTIM_HIT = 2'd1,
    OUT_MISS       = 2'd2,
    OUT_MISS_DROP  = 2'd3
  } outcome_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAIN,
    ST_VIC,
    ST_UPD,
    ST_DONE
  } salc_state_e;

  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } line_entry_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [STAMP_W-1:0] stamp;
  } victim_entry_t;

endpackage

`default_nettype wire

// File: hw/rtl/salc_ram.sv
`default_nettype none

// Simple dual-port synchronous RAM: one write and one read a cycle, read data registered.
module salc_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hw/rtl/set_assoc_lru_cache_with_victim_buffer_unit.sv
// Set-associative LRU cache model with a fully associative victim buffer.
// Each input beat on the s_axis channel carries one 64-bit byte address; each
// accepted beat yields exactly one result beat on m_axis whose low two bits
// give the outcome: main hit, victim hit, miss, or miss with a line dropped.
// Geometry is set through the plain write port (line size, ways in use and
// victim entries in use); the user is to write it only while the block is
// idle, which the block itself does not enforce. An access is accepted in
// the idle state, then reads the ways of its set one per cycle from the line
// RAM, stopping early on a hit. On a main miss the victim RAM is scanned one
// entry per cycle (skipped when the buffer is disabled), followed by an
// update state and a state that loads the output register; a main hit goes
// straight to the output state. The serial scans of the two RAMs set the cost.
// After reset the line RAM is swept clean, one entry per cycle, over all
// 2**(CACHE_BYTES_LOG2-2) + MAX_WAYS entries, during which s_axis_tready stays
// low; the victim valid bits are flip-flops cleared at once.
// The result waits in an output register; a new address is taken while it
// waits, and the block only stalls at the end of the next access if the
// receiver has still not taken the previous beat.
`default_nettype none

module set_assoc_lru_cache_with_victim_buffer_unit #(
  parameter int unsigned CACHE_BYTES_LOG2 = 12,
  parameter int unsigned MAX_WAYS         = 8,
  parameter int unsigned MAX_VICTIMS      = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // tdata: address[63:0]
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [salc_pkg::ADDR_W-1:0]      s_axis_tdata,
  // tdata: outcome[1:0], zeros above
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic      [7:0]                       m_axis_tdata,
  input  wire logic                             cfg_we_i,
  input  wire logic [salc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [salc_pkg::CFG_W-1:0]       cfg_wdata_i
);

  import salc_pkg::*;

  // Set index width at the smallest line size; the line RAM holds every
  // flat entry index set * ways + way that any geometry can produce.
  localparam int unsigned SETW       = CACHE_BYTES_LOG2 - 2;
  localparam int unsigned SBW        = $clog2(SETW + 1);
  localparam int unsigned LINE_SLOTS = (1 << SETW) + MAX_WAYS;
  localparam int unsigned KW         = $clog2(LINE_SLOTS);
  localparam int unsigned WCW        = $clog2(MAX_WAYS + 1);
  localparam int unsigned VDEPTH     = (MAX_VICTIMS < VIC_FIELD_MAX) ? MAX_VICTIMS
                                                                     : VIC_FIELD_MAX;
  localparam int unsigned VAW        = (VDEPTH > 1) ? $clog2(VDEPTH) : 1;
  localparam int unsigned VCW        = $clog2(VDEPTH + 1);

  // Configuration registers.
  logic [OFF_W-1:0] off_q;
  logic [WL_W-1:0]  wl_q;
  logic [VIC_W-1:0] vic_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= OFF_RESET;
      wl_q  <= '0;
      vic_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BLOCK_OFFSET: off_q <= cfg_wdata_i[OFF_W-1:0];
        REG_WAYS_LOG2:    wl_q  <= cfg_wdata_i[WL_W-1:0];
        REG_VICTIMS:      vic_q <= cfg_wdata_i[VIC_W-1:0];
        default: ;
      endcase
    end
  end

  // Geometry derived from the registers, with the out-of-range values saturated.
  logic [OFF_W-1:0]  b_c;
  logic [WCW-1:0]    ways_c;
  logic [SBW-1:0]    sb_c;
  logic [VCW-1:0]    v_c;
  logic [KEY_W-1:0]  key_c;
  logic [SETW-1:0]   set_c;
  logic [KEY_W-1:0]  tag_c;
  logic [SETW+WCW-1:0] prod_c;
  logic [KW-1:0]     base_c;

  always_comb begin
    int sb_int;
    int unsigned pow;
    sb_int = 0;
    pow    = 0;
    if (off_q < OFF_MIN) begin
      b_c = OFF_MIN;
    end else if (off_q > OFF_MAX) begin
      b_c = OFF_MAX;
    end else begin
      b_c = off_q;
    end
    pow = 1 << wl_q;
    if (pow > MAX_WAYS) begin
      ways_c = WCW'(MAX_WAYS);
    end else begin
      ways_c = WCW'(pow);
    end
    sb_int = int'(CACHE_BYTES_LOG2) - int'(b_c) - int'(wl_q);
    if (sb_int < 0) begin
      sb_c = '0;
    end else begin
      sb_c = SBW'(sb_int);
    end
    if (int'(vic_q) > int'(VDEPTH)) begin
      v_c = VCW'(VDEPTH);
    end else begin
      v_c = VCW'(vic_q);
    end
    key_c  = KEY_W'(s_axis_tdata >> b_c);
    set_c  = SETW'(key_c) & ~({SETW{1'b1}} << sb_c);
    tag_c  = key_c >> sb_c;
    prod_c = (SETW+WCW)'(set_c) * (SETW+WCW)'(ways_c);
    base_c = KW'(prod_c);
  end

  // Control and access registers.
  salc_state_e state_q, state_d;
  logic [KW-1:0]      clr_q, clr_d;
  logic [STAMP_W-1:0] cnt_q, cnt_d;
  logic [STAMP_W-1:0] now_q, now_d;
  logic [KEY_W-1:0]   key_q, key_d;
  logic [SETW-1:0]    set_q, set_d;
  logic [KEY_W-1:0]   tag_q, tag_d;
  logic [KW-1:0]      base_q, base_d;
  logic [WCW-1:0]     ways_q, ways_d;
  logic [SBW-1:0]     sb_q, sb_d;
  logic [VCW-1:0]     v_q, v_d;

  // Main scan state.
  logic [WCW-1:0]     widx_q, widx_d;
  logic               rvld_q, rvld_d;
  logic [WCW-1:0]     rway_q, rway_d;
  logic               free_found_q, free_found_d;
  logic [WCW-1:0]     free_way_q, free_way_d;
  logic               lru_found_q, lru_found_d;
  logic [WCW-1:0]     lru_way_q, lru_way_d;
  logic [KEY_W-1:0]   lru_tag_q, lru_tag_d;
  logic [STAMP_W-1:0] lru_stamp_q, lru_stamp_d;

  // Victim scan state.
  logic [VCW-1:0]     vidx_q, vidx_d;
  logic               rvv_q, rvv_d;
  logic [VAW-1:0]     rvidx_q, rvidx_d;
  logic               vhit_found_q, vhit_found_d;
  logic [VAW-1:0]     vhit_q, vhit_d;
  logic               vfree_found_q, vfree_found_d;
  logic [VAW-1:0]     vfree_q, vfree_d;
  logic               vlru_found_q, vlru_found_d;
  logic [VAW-1:0]     vlru_q, vlru_d;
  logic [STAMP_W-1:0] vlru_stamp_q, vlru_stamp_d;
  logic               vvalid_q [VDEPTH];
  logic               vvalid_d [VDEPTH];

  // Result.
  outcome_e           outcome_q, outcome_d;
  logic               m_valid_q, m_valid_d;
  logic [1:0]         m_data_q, m_data_d;

  // RAM ports.
  logic                       l_we, l_re;
  logic [KW-1:0]              l_waddr, l_raddr;
  line_entry_t                l_wdata, l_rdata;
  logic [$bits(line_entry_t)-1:0] l_rdata_raw;
  logic                       v_we, v_re;
  logic [VAW-1:0]             v_waddr, v_raddr;
  victim_entry_t              v_wdata, v_rdata;
  logic [$bits(victim_entry_t)-1:0] v_rdata_raw;

  salc_ram #(
    .DEPTH (LINE_SLOTS),
    .WIDTH ($bits(line_entry_t))
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (l_waddr),
    .wdata_i (l_wdata),
    .re_i    (l_re),
    .raddr_i (l_raddr),
    .rdata_o (l_rdata_raw)
  );

  salc_ram #(
    .DEPTH (VDEPTH),
    .WIDTH ($bits(victim_entry_t))
  ) u_victim_ram (
    .clk_i   (clk_i),
    .we_i    (v_we),
    .waddr_i (v_waddr),
    .wdata_i (v_wdata),
    .re_i    (v_re),
    .raddr_i (v_raddr),
    .rdata_o (v_rdata_raw)
  );

  assign l_rdata = line_entry_t'(l_rdata_raw);
  assign v_rdata = victim_entry_t'(v_rdata_raw);

  // Decisions on the data returned by the RAMs in this cycle.
  logic hit_now, main_last, vic_last, vrd_valid, accept, out_load;

  assign accept    = (state_q == ST_IDLE) && s_axis_tvalid;
  assign hit_now   = (state_q == ST_MAIN) && rvld_q && l_rdata.valid &&
                     (l_rdata.tag == tag_q);
  assign main_last = (state_q == ST_MAIN) && rvld_q && !hit_now &&
                     (rway_q == ways_q - WCW'(1));
  assign vic_last  = (state_q == ST_VIC) && rvv_q &&
                     (VCW'(rvidx_q) == v_q - VCW'(1));
  assign vrd_valid = vvalid_q[rvidx_q];
  assign out_load  = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == KW'(LINE_SLOTS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_MAIN;
        end
      end
      ST_MAIN: begin
        if (hit_now) begin
          state_d = ST_DONE;
        end else if (main_last) begin
          state_d = (v_q != '0) ? ST_VIC : ST_UPD;
        end
      end
      ST_VIC: begin
        if (vic_last) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // Datapath, RAM controls and outputs.
  always_comb begin
    logic [WCW-1:0]   fill_way;
    logic [KEY_W-1:0] evkey;
    logic [VAW-1:0]   slot;
    logic             vclr;
    fill_way = free_found_q ? free_way_q : lru_way_q;
    evkey    = KEY_W'(lru_tag_q << sb_q) | KEY_W'(set_q);
    slot     = vhit_q;
    vclr     = 1'b0;

    clr_d   = clr_q;
    cnt_d   = cnt_q;
    now_d   = now_q;
    key_d   = key_q;
    set_d   = set_q;
    tag_d   = tag_q;
    base_d  = base_q;
    ways_d  = ways_q;
    sb_d    = sb_q;
    v_d     = v_q;

    widx_d       = widx_q;
    rvld_d       = 1'b0;
    rway_d       = rway_q;
    free_found_d = free_found_q;
    free_way_d   = free_way_q;
    lru_found_d  = lru_found_q;
    lru_way_d    = lru_way_q;
    lru_tag_d    = lru_tag_q;
    lru_stamp_d  = lru_stamp_q;

    vidx_d        = vidx_q;
    rvv_d         = 1'b0;
    rvidx_d       = rvidx_q;
    vhit_found_d  = vhit_found_q;
    vhit_d        = vhit_q;
    vfree_found_d = vfree_found_q;
    vfree_d       = vfree_q;
    vlru_found_d  = vlru_found_q;
    vlru_d        = vlru_q;
    vlru_stamp_d  = vlru_stamp_q;
    vvalid_d      = vvalid_q;

    outcome_d = outcome_q;
    m_data_d  = m_data_q;
    m_valid_d = (m_valid_q && m_axis_tready) ? 1'b0 : m_valid_q;

    l_we    = 1'b0;
    l_waddr = base_q + KW'(fill_way);
    l_wdata = '{valid: 1'b1, tag: tag_q, stamp: now_q};
    l_re    = 1'b0;
    l_raddr = base_q + KW'(widx_q);
    v_we    = 1'b0;
    v_waddr = slot;
    v_wdata = '{key: evkey, stamp: lru_stamp_q};
    v_re    = 1'b0;
    v_raddr = vidx_q[VAW-1:0];

    case (state_q)
      ST_CLEAR: begin
        l_we    = 1'b1;
        l_waddr = clr_q;
        l_wdata = '0;
        clr_d   = clr_q + KW'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          now_d  = cnt_q;
          cnt_d  = cnt_q + STAMP_W'(1);
          key_d  = key_c;
          set_d  = set_c;
          tag_d  = tag_c;
          base_d = base_c;
          ways_d = ways_c;
          sb_d   = sb_c;
          v_d    = v_c;
          widx_d        = '0;
          vidx_d        = '0;
          free_found_d  = 1'b0;
          lru_found_d   = 1'b0;
          vhit_found_d  = 1'b0;
          vfree_found_d = 1'b0;
          vlru_found_d  = 1'b0;
        end
      end
      ST_MAIN: begin
        // Issue the next way while the previous one is being looked at.
        if ((widx_q < ways_q) && !hit_now) begin
          l_re   = 1'b1;
          rvld_d = 1'b1;
          rway_d = widx_q;
          widx_d = widx_q + WCW'(1);
        end
        if (rvld_q) begin
          if (!l_rdata.valid) begin
            // Ascending scan: the last empty way seen is the highest one.
            free_found_d = 1'b1;
            free_way_d   = rway_q;
          end else if (hit_now) begin
            l_we      = 1'b1;
            l_waddr   = base_q + KW'(rway_q);
            outcome_d = OUT_MAIN_HIT;
          end else if (!lru_found_q || (l_rdata.stamp < lru_stamp_q)) begin
            lru_found_d = 1'b1;
            lru_way_d   = rway_q;
            lru_tag_d   = l_rdata.tag;
            lru_stamp_d = l_rdata.stamp;
          end
        end
      end
      ST_VIC: begin
        if (vidx_q < v_q) begin
          v_re    = 1'b1;
          rvv_d   = 1'b1;
          rvidx_d = vidx_q[VAW-1:0];
          vidx_d  = vidx_q + VCW'(1);
        end
        if (rvv_q) begin
          if (!vrd_valid) begin
            if (!vfree_found_q) begin
              vfree_found_d = 1'b1;
              vfree_d       = rvidx_q;
            end
          end else if (v_rdata.key == key_q) begin
            if (!vhit_found_q) begin
              vhit_found_d = 1'b1;
              vhit_d       = rvidx_q;
            end
          end else if (!vlru_found_q || (v_rdata.stamp < vlru_stamp_q)) begin
            vlru_found_d = 1'b1;
            vlru_d       = rvidx_q;
            vlru_stamp_d = v_rdata.stamp;
          end
        end
      end
      ST_UPD: begin
        l_we = 1'b1;
        if (vhit_found_q) begin
          // The line returns to its set; the victim slot takes the pushed-out
          // line if the set was full, and is freed otherwise.
          outcome_d = OUT_VICTIM_HIT;
          slot      = vhit_q;
          if (free_found_q) begin
            vclr = 1'b1;
          end else begin
            v_we = 1'b1;
          end
        end else begin
          outcome_d = OUT_MISS;
          if (!free_found_q) begin
            if (vfree_found_q) begin
              slot = vfree_q;
              v_we = 1'b1;
            end else begin
              outcome_d = OUT_MISS_DROP;
              slot      = vlru_q;
              v_we      = vlru_found_q;
            end
          end
        end
        v_waddr = slot;
        if (v_we) begin
          vvalid_d[slot] = 1'b1;
        end
        if (vclr) begin
          vvalid_d[slot] = 1'b0;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          m_valid_d = 1'b1;
          m_data_d  = outcome_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_q         <= '0;
      cnt_q         <= '0;
      rvld_q        <= 1'b0;
      rvv_q         <= 1'b0;
      m_valid_q     <= 1'b0;
      widx_q        <= '0;
      vidx_q        <= '0;
      free_found_q  <= 1'b0;
      lru_found_q   <= 1'b0;
      vhit_found_q  <= 1'b0;
      vfree_found_q <= 1'b0;
      vlru_found_q  <= 1'b0;
      for (int i = 0; i < VDEPTH; i++) begin
        vvalid_q[i] <= 1'b0;
      end
    end else begin
      state_q       <= state_d;
      clr_q         <= clr_d;
      cnt_q         <= cnt_d;
      rvld_q        <= rvld_d;
      rvv_q         <= rvv_d;
      m_valid_q     <= m_valid_d;
      widx_q        <= widx_d;
      vidx_q        <= vidx_d;
      free_found_q  <= free_found_d;
      lru_found_q   <= lru_found_d;
      vhit_found_q  <= vhit_found_d;
      vfree_found_q <= vfree_found_d;
      vlru_found_q  <= vlru_found_d;
      vvalid_q      <= vvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q        <= now_d;
    key_q        <= key_d;
    set_q        <= set_d;
    tag_q        <= tag_d;
    base_q       <= base_d;
    ways_q       <= ways_d;
    sb_q         <= sb_d;
    v_q          <= v_d;
    rway_q       <= rway_d;
    free_way_q   <= free_way_d;
    lru_way_q    <= lru_way_d;
    lru_tag_q    <= lru_tag_d;
    lru_stamp_q  <= lru_stamp_d;
    rvidx_q      <= rvidx_d;
    vhit_q       <= vhit_d;
    vfree_q      <= vfree_d;
    vlru_q       <= vlru_d;
    vlru_stamp_q <= vlru_stamp_d;
    outcome_q    <= outcome_d;
    m_data_q     <= m_data_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'b0, m_data_q};

endmodule

`default_nettype wire

// File: hw/rtl/salc_checker.sv
`default_nettype none

module salc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_tvalid_i,
  input wire logic       s_tready_i,
  input wire logic       m_tvalid_i,
  input wire logic       m_tready_i,
  input wire logic [7:0] m_tdata_i
);

  // A result beat held back by the receiver keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i))
    else $error("result beat changed while stalled");

  // After accepting an input, the block is not ready in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_i |=> !s_tready_i)
    else $error("input accepted on consecutive cycles");

  // A new result appears only at the end of an access, never while idle.
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid_i) |-> !$past(s_tready_i))
    else $error("result appeared while the block was idle");

  // Only the outcome bits of the result are ever set.
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i |-> (m_tdata_i[7:2] == 6'b0))
    else $error("padding bits of the result are set");

endmodule

bind set_assoc_lru_cache_with_victim_buffer_unit salc_checker u_salc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid),
  .s_tready_i (s_axis_tready),
  .m_tvalid_i (m_axis_tvalid),
  .m_tready_i (m_axis_tready),
  .m_tdata_i  (m_axis_tdata)
);

`default_nettype wire

// File: tb/set_assoc_lru_cache_with_victim_buffer_unit_tb.sv
module set_assoc_lru_cache_with_victim_buffer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import salc_pkg::*;

  // Geometry of the instance; these match the block's default parameters.
  localparam int unsigned CACHE_LOG2 = 12;
  localparam int unsigned WAYS_MAX   = 8;
  localparam int unsigned VICS_MAX   = 16;
  localparam int unsigned LINE_DEPTH = (1 << (CACHE_LOG2 - 2)) + WAYS_MAX;
  localparam int unsigned GAP_MAX    = 17;
  // The slowest correct run is roughly 650 beats, plus the sweep after reset
  // and the long receiver hold-off. Several times that is allowed before the
  // run is abandoned.
  localparam int unsigned CYCLE_LIMIT = 400000;
  // A quiet spell of this length means the block has settled.
  localparam int unsigned SETTLE_CYCLES = 60;
  localparam int unsigned HOLD_CYCLES   = 400;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [ADDR_W-1:0]    s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [7:0]           m_axis_tdata;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;

  set_assoc_lru_cache_with_victim_buffer_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Shadow copy of the cache state, kept in step with every accepted beat.
  bit                 line_valid [LINE_DEPTH];
  logic [KEY_W-1:0]   line_tag   [LINE_DEPTH];
  logic [STAMP_W-1:0] line_stamp [LINE_DEPTH];
  bit                 vic_valid  [VICS_MAX];
  logic [KEY_W-1:0]   vic_key    [VICS_MAX];
  logic [STAMP_W-1:0] vic_stamp  [VICS_MAX];
  logic [STAMP_W-1:0] access_cnt = '0;

  // Shadow copy of the configuration registers.
  logic [OFF_W-1:0] shadow_off;
  logic [WL_W-1:0]  shadow_wl;
  logic [VIC_W-1:0] shadow_vic;

  logic [ADDR_W-1:0] pending_addrs[$];
  outcome_e          expected_outcomes[$];
  int unsigned       error_cnt = 0;
  int unsigned       cycle_cnt = 0;
  int unsigned       send_gap;
  int unsigned       recv_stall;
  bit                no_idle;
  bit                hold_arm;
  logic              long_hold;

  // Works out the outcome of one access and updates the shadow state, the
  // same way the block does: main store first, then the victim buffer.
  function automatic outcome_e lookup_access(input logic [ADDR_W-1:0] addr);
    int unsigned      boff;
    int unsigned      ways;
    int               sb;
    int unsigned      vmax;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] set_idx;
    logic [KEY_W-1:0] tag;
    logic [STAMP_W-1:0] now;
    int unsigned      base;
    int unsigned      k;
    int               free_way;
    int               lru_way;
    int               vhit;
    int               vfree;
    int               vlru;
    int               slot;
    outcome_e         res;
    free_way = -1;
    lru_way  = -1;
    vhit     = -1;
    vfree    = -1;
    vlru     = -1;
    boff = shadow_off;
    if (boff < OFF_MIN) boff = OFF_MIN;
    if (boff > OFF_MAX) boff = OFF_MAX;
    ways = 1 << shadow_wl;
    if (ways > WAYS_MAX) ways = WAYS_MAX;
    sb = int'(CACHE_LOG2) - int'(boff) - int'(shadow_wl);
    if (sb < 0) sb = 0;
    vmax = shadow_vic;
    if (vmax > VICS_MAX) vmax = VICS_MAX;

    key     = KEY_W'(addr >> boff);
    set_idx = key & ((KEY_W'(1) << sb) - KEY_W'(1));
    tag     = key >> sb;
    base    = int'(set_idx) * ways;
    now     = access_cnt;
    access_cnt = access_cnt + 1;

    for (int unsigned w = 0; w < ways; w++) begin
      k = base + w;
      if (k < LINE_DEPTH) begin
        if (!line_valid[k]) begin
          free_way = int'(w);
        end else if (line_tag[k] == tag) begin
          line_stamp[k] = now;
          return OUT_MAIN_HIT;
        end else if (lru_way < 0 || line_stamp[k] < line_stamp[base + lru_way]) begin
          lru_way = int'(w);
        end
      end
    end

    for (int unsigned i = 0; i < vmax; i++) begin
      if (!vic_valid[i]) begin
        if (vfree < 0) vfree = int'(i);
      end else if (vic_key[i] == key) begin
        if (vhit < 0) vhit = int'(i);
      end else if (vlru < 0 || vic_stamp[i] < vic_stamp[vlru]) begin
        vlru = int'(i);
      end
    end

    if (free_way < 0 && lru_way < 0) return OUT_MISS;

    // On a full set the least recently used way moves to the victim
    // buffer: into the slot that hit, else a free slot, else the buffer's
    // own oldest entry, which is then lost.
    if (vhit >= 0) begin
      res = OUT_VICTIM_HIT;
      vic_valid[vhit] = 1'b0;
      slot = (free_way < 0) ? vhit : -1;
    end else begin
      res  = OUT_MISS;
      slot = -1;
      if (free_way < 0) begin
        slot = vfree;
        if (slot < 0) begin
          res  = OUT_MISS_DROP;
          slot = vlru;
        end
      end
    end
    if (slot >= 0) begin
      k = base + lru_way;
      vic_valid[slot] = 1'b1;
      vic_key[slot]   = (line_tag[k] << sb) | set_idx;
      vic_stamp[slot] = line_stamp[k];
    end

    k = base + ((free_way >= 0) ? free_way : lru_way);
    line_valid[k] = 1'b1;
    line_tag[k]   = tag;
    line_stamp[k] = now;
    return res;
  endfunction

  // Sender: presents queued addresses, with a random gap before each beat
  // unless the current phase runs back to back.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      send_gap      = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_outcomes.insert(expected_outcomes.size(), lookup_access(s_axis_tdata));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap != 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_addrs.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_addrs.pop_front();
          send_gap = no_idle ? 0 : $urandom_range(0, GAP_MAX);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result beat against the oldest expectation and
  // then stalls for a random number of cycles, or for the long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_stall    = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_outcomes.size() == 0) begin
          $error("unexpected result beat: outcome actual %0d", m_axis_tdata[1:0]);
          error_cnt++;
        end else begin
          outcome_e want;
          want = expected_outcomes.pop_front();
          if (m_axis_tdata[1:0] !== want) begin
            $error("outcome: expected %0d (%s), actual %0d",
                   want, want.name(), m_axis_tdata[1:0]);
            error_cnt++;
          end
          if (m_axis_tdata[7:2] !== 6'd0) begin
            $error("tdata padding: expected 0, actual %0h", m_axis_tdata[7:2]);
            error_cnt++;
          end
        end
        recv_stall = no_idle ? 0 : $urandom_range(0, GAP_MAX);
      end
      if (long_hold) begin
        m_axis_tready <= 1'b0;
      end else if (recv_stall != 0) begin
        recv_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Long hold-off of the receiver, counted here once the stimulus arms it,
  // so that the output register fills and the block stops taking input.
  initial begin
    long_hold = 1'b0;
    wait (hold_arm);
    @(posedge clk_i);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    long_hold <= 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic add_addr(input logic [ADDR_W-1:0] addr);
    pending_addrs.insert(pending_addrs.size(), addr);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_BLOCK_OFFSET: shadow_off = OFF_W'(val);
      REG_WAYS_LOG2:    shadow_wl  = WL_W'(val);
      REG_VICTIMS:      shadow_vic = VIC_W'(val);
      default: ;
    endcase
  endtask

  task automatic set_geometry(input int unsigned off, input int unsigned wl,
                              input int unsigned vics);
    write_reg(REG_BLOCK_OFFSET, CFG_W'(off));
    write_reg(REG_WAYS_LOG2, CFG_W'(wl));
    write_reg(REG_VICTIMS, CFG_W'(vics));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Blocks until every queued address has gone in and every result has
  // come back, then lets the block settle before the next register write.
  // The check is repeated after the quiet spell so that a beat offered on
  // the very cycle of the first check is not missed.
  task automatic drain;
    do begin
      while (pending_addrs.size() != 0 || s_axis_tvalid || expected_outcomes.size() != 0)
        @(posedge clk_i);
      repeat (SETTLE_CYCLES) @(posedge clk_i);
    end while (pending_addrs.size() != 0 || s_axis_tvalid ||
               expected_outcomes.size() != 0);
  endtask

  // Random traffic for one phase. Most addresses come from a small working
  // set, half of which shares its low bits so that sets overflow and lines
  // travel through the victim buffer; the rest are fully random addresses.
  task automatic queue_traffic(input int unsigned count);
    logic [ADDR_W-1:0] pool[48];
    int unsigned       pool_sz;
    int unsigned       pick;
    pool_sz = $urandom_range(3, 48);
    for (int i = 0; i < pool_sz; i++) begin
      pool[i] = {$urandom, $urandom};
      if (i % 2 == 0) pool[i][11:0] = 12'(($urandom_range(0, 3)) << 8);
      pool[i][1:0] = 2'b00;
    end
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 9);
      if (pick < 8)
        add_addr(pool[$urandom_range(0, pool_sz - 1)] | $urandom_range(0, 3));
      else
        add_addr({$urandom, $urandom});
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    no_idle       = 1'b0;
    hold_arm      = 1'b0;
    shadow_off    = OFF_RESET;
    shadow_wl     = '0;
    shadow_vic    = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The line store is swept after reset; ready rises once it is clean.
    while (!s_axis_tready) @(posedge clk_i);

    // Reset geometry: 16-byte lines, direct mapped, no victim buffer, so a
    // conflicting line is dropped. Extremes of the address come first.
    add_addr(64'h0);
    add_addr(64'hFFFF_FFFF_FFFF_FFFF);
    add_addr(64'h0000_0000_0000_000F);
    add_addr(64'h0000_0000_0000_1000);
    add_addr(64'h8000_0000_0000_0000);
    add_addr(64'h0);
    drain();

    // Two ways and two victim slots: fill a set, push lines into the buffer,
    // swap one back, and overflow the buffer so its oldest entry goes.
    set_geometry(4, 1, 2);
    for (int t = 1; t <= 6; t++) add_addr(64'(t) << 11);
    add_addr(64'h0000_0000_0000_0800);
    add_addr(64'h0000_0000_0000_1000);
    add_addr(64'h0000_0000_0000_1804);
    add_addr(64'h0000_0000_0000_2000);
    drain();
    // Register values beyond the range: offsets clamp and the victim count
    // saturates; lines kept under the old geometry stay where they lie.
    set_geometry(0, 3, VIC_FIELD_MAX);
    add_addr(64'h0000_0000_0000_0800);
    add_addr(64'h5555_5555_5555_5555);
    add_addr(64'hAAAA_AAAA_AAAA_AAAA);
    drain();
    set_geometry(15, 2, 1);
    add_addr(64'hFFFF_FFFF_FFFF_FF00);
    add_addr(64'h0);
    add_addr(64'h0000_0000_0000_0100);
    drain();

    // Random phases across the geometries, extremes among them.
    set_geometry(2, 0, 1);
    queue_traffic(75);
    drain();

    set_geometry(8, 3, 16);
    queue_traffic(75);
    drain();

    // Back to back on both sides, then the receiver holds off for a long
    // stretch while the sender keeps offering beats.
    set_geometry(5, 3, 8);
    no_idle = 1'b1;
    queue_traffic(80);
    hold_arm = 1'b1;
    drain();
    no_idle = 1'b0;

    set_geometry(3, 2, 17);
    queue_traffic(75);
    drain();

    set_geometry(9, 1, 4);
    queue_traffic(75);
    drain();

    set_geometry(6, 3, 0);
    queue_traffic(75);
    drain();

    set_geometry(2, 3, 16);
    queue_traffic(75);
    drain();

    set_geometry(4, 2, 3);
    queue_traffic(75);
    drain();

    if (error_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
